// ----- rtl/r2h_pkg.sv -----
package r2h_pkg;

    localparam logic [13:0] KanaN        = 14'h3093;
    localparam logic [13:0] KanaSmallTsu = 14'h3063;
    localparam logic [7:0]  UpperA       = 8'h41;
    localparam logic [7:0]  UpperZ       = 8'h5A;
    localparam logic [7:0]  CaseOffset   = 8'h20;
    localparam int unsigned BufDepth     = 3;

    typedef enum logic [1:0] {
        FUNC_CHAR      = 2'd0,
        FUNC_BACKSPACE = 2'd1,
        FUNC_CLEAR     = 2'd2
    } func_e;

    typedef struct packed {
        logic        hit;
        logic [13:0] k0;
        logic [13:0] k1;
    } entry_t;

    typedef struct packed {
        logic        two;
        logic        kana_valid;
        logic [13:0] kana0;
        logic [13:0] kana1;
        logic        delete_request;
        logic [8:0]  pending_chars;
        logic        stuck;
    } res_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= UpperA && c <= UpperZ) begin
            return c + CaseOffset;
        end
        return c;
    endfunction

    function automatic logic is_vowel(input logic [7:0] c);
        return (c == "a") || (c == "i") || (c == "u") || (c == "e") || (c == "o");
    endfunction

    function automatic entry_t mk(input logic [13:0] k0, input logic [13:0] k1);
        entry_t e;
        e.hit = 1'b1;
        e.k0  = k0;
        e.k1  = k1;
        return e;
    endfunction

    function automatic entry_t lookup3(input logic [23:0] s);
        entry_t e;
        e = '0;
        case (s)
            "shi": e = mk(14'h3057, 14'h0);
            "chi": e = mk(14'h3061, 14'h0);
            "tsu": e = mk(14'h3064, 14'h0);
            "sha": e = mk(14'h3057, 14'h3083);
            "shu": e = mk(14'h3057, 14'h3085);
            "sho": e = mk(14'h3057, 14'h3087);
            "cha": e = mk(14'h3061, 14'h3083);
            "chu": e = mk(14'h3061, 14'h3085);
            "cho": e = mk(14'h3061, 14'h3087);
            "tya": e = mk(14'h3061, 14'h3083);
            "tyu": e = mk(14'h3061, 14'h3085);
            "tyo": e = mk(14'h3061, 14'h3087);
            "sya": e = mk(14'h3057, 14'h3083);
            "syu": e = mk(14'h3057, 14'h3085);
            "syo": e = mk(14'h3057, 14'h3087);
            "nya": e = mk(14'h306B, 14'h3083);
            "nyu": e = mk(14'h306B, 14'h3085);
            "nyo": e = mk(14'h306B, 14'h3087);
            "hya": e = mk(14'h3072, 14'h3083);
            "hyu": e = mk(14'h3072, 14'h3085);
            "hyo": e = mk(14'h3072, 14'h3087);
            "mya": e = mk(14'h307F, 14'h3083);
            "myu": e = mk(14'h307F, 14'h3085);
            "myo": e = mk(14'h307F, 14'h3087);
            "rya": e = mk(14'h308A, 14'h3083);
            "ryu": e = mk(14'h308A, 14'h3085);
            "ryo": e = mk(14'h308A, 14'h3087);
            "gya": e = mk(14'h304E, 14'h3083);
            "gyu": e = mk(14'h304E, 14'h3085);
            "gyo": e = mk(14'h304E, 14'h3087);
            "bya": e = mk(14'h3073, 14'h3083);
            "byu": e = mk(14'h3073, 14'h3085);
            "byo": e = mk(14'h3073, 14'h3087);
            "pya": e = mk(14'h3074, 14'h3083);
            "pyu": e = mk(14'h3074, 14'h3085);
            "pyo": e = mk(14'h3074, 14'h3087);
            "kya": e = mk(14'h304D, 14'h3083);
            "kyu": e = mk(14'h304D, 14'h3085);
            "kyo": e = mk(14'h304D, 14'h3087);
            "jya": e = mk(14'h3058, 14'h3083);
            "jyu": e = mk(14'h3058, 14'h3085);
            "jyo": e = mk(14'h3058, 14'h3087);
            "xtu": e = mk(14'h3063, 14'h0);
            "xya": e = mk(14'h3083, 14'h0);
            "xyu": e = mk(14'h3085, 14'h0);
            "xyo": e = mk(14'h3087, 14'h0);
            "xwa": e = mk(14'h308E, 14'h0);
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic entry_t lookup2(input logic [15:0] s);
        entry_t e;
        e = '0;
        case (s)
            "ka": e = mk(14'h304B, 14'h0);
            "ki": e = mk(14'h304D, 14'h0);
            "ku": e = mk(14'h304F, 14'h0);
            "ke": e = mk(14'h3051, 14'h0);
            "ko": e = mk(14'h3053, 14'h0);
            "sa": e = mk(14'h3055, 14'h0);
            "si": e = mk(14'h3057, 14'h0);
            "su": e = mk(14'h3059, 14'h0);
            "se": e = mk(14'h305B, 14'h0);
            "so": e = mk(14'h305D, 14'h0);
            "ta": e = mk(14'h305F, 14'h0);
            "ti": e = mk(14'h3061, 14'h0);
            "tu": e = mk(14'h3064, 14'h0);
            "te": e = mk(14'h3066, 14'h0);
            "to": e = mk(14'h3068, 14'h0);
            "na": e = mk(14'h306A, 14'h0);
            "ni": e = mk(14'h306B, 14'h0);
            "nu": e = mk(14'h306C, 14'h0);
            "ne": e = mk(14'h306D, 14'h0);
            "no": e = mk(14'h306E, 14'h0);
            "ha": e = mk(14'h306F, 14'h0);
            "hi": e = mk(14'h3072, 14'h0);
            "hu": e = mk(14'h3075, 14'h0);
            "he": e = mk(14'h3078, 14'h0);
            "ho": e = mk(14'h307B, 14'h0);
            "ma": e = mk(14'h307E, 14'h0);
            "mi": e = mk(14'h307F, 14'h0);
            "mu": e = mk(14'h3080, 14'h0);
            "me": e = mk(14'h3081, 14'h0);
            "mo": e = mk(14'h3082, 14'h0);
            "ya": e = mk(14'h3084, 14'h0);
            "yi": e = mk(14'h3044, 14'h0);
            "yu": e = mk(14'h3086, 14'h0);
            "ye": e = mk(14'h3044, 14'h3047);
            "yo": e = mk(14'h3088, 14'h0);
            "ra": e = mk(14'h3089, 14'h0);
            "ri": e = mk(14'h308A, 14'h0);
            "ru": e = mk(14'h308B, 14'h0);
            "re": e = mk(14'h308C, 14'h0);
            "ro": e = mk(14'h308D, 14'h0);
            "wa": e = mk(14'h308F, 14'h0);
            "wi": e = mk(14'h3090, 14'h0);
            "wu": e = mk(14'h3046, 14'h0);
            "we": e = mk(14'h3091, 14'h0);
            "wo": e = mk(14'h3092, 14'h0);
            "ga": e = mk(14'h304C, 14'h0);
            "gi": e = mk(14'h304E, 14'h0);
            "gu": e = mk(14'h3050, 14'h0);
            "ge": e = mk(14'h3052, 14'h0);
            "go": e = mk(14'h3054, 14'h0);
            "za": e = mk(14'h3056, 14'h0);
            "zi": e = mk(14'h3058, 14'h0);
            "zu": e = mk(14'h305A, 14'h0);
            "ze": e = mk(14'h305C, 14'h0);
            "zo": e = mk(14'h305E, 14'h0);
            "da": e = mk(14'h3060, 14'h0);
            "di": e = mk(14'h3062, 14'h0);
            "du": e = mk(14'h3065, 14'h0);
            "de": e = mk(14'h3067, 14'h0);
            "do": e = mk(14'h3069, 14'h0);
            "ba": e = mk(14'h3070, 14'h0);
            "bi": e = mk(14'h3073, 14'h0);
            "bu": e = mk(14'h3076, 14'h0);
            "be": e = mk(14'h3079, 14'h0);
            "bo": e = mk(14'h307C, 14'h0);
            "pa": e = mk(14'h3071, 14'h0);
            "pi": e = mk(14'h3074, 14'h0);
            "pu": e = mk(14'h3077, 14'h0);
            "pe": e = mk(14'h307A, 14'h0);
            "po": e = mk(14'h307D, 14'h0);
            "fa": e = mk(14'h3075, 14'h3041);
            "fi": e = mk(14'h3075, 14'h3043);
            "fu": e = mk(14'h3075, 14'h0);
            "fe": e = mk(14'h3075, 14'h3047);
            "fo": e = mk(14'h3075, 14'h3049);
            "ja": e = mk(14'h3058, 14'h3083);
            "ji": e = mk(14'h3058, 14'h0);
            "ju": e = mk(14'h3058, 14'h3085);
            "je": e = mk(14'h3058, 14'h3047);
            "jo": e = mk(14'h3058, 14'h3087);
            "nn": e = mk(14'h3093, 14'h0);
            "xa": e = mk(14'h3041, 14'h0);
            "xi": e = mk(14'h3043, 14'h0);
            "xu": e = mk(14'h3045, 14'h0);
            "xe": e = mk(14'h3047, 14'h0);
            "xo": e = mk(14'h3049, 14'h0);
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic entry_t lookup1(input logic [7:0] s);
        entry_t e;
        e = '0;
        case (s)
            "a": e = mk(14'h3042, 14'h0);
            "i": e = mk(14'h3044, 14'h0);
            "u": e = mk(14'h3046, 14'h0);
            "e": e = mk(14'h3048, 14'h0);
            "o": e = mk(14'h304A, 14'h0);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/r2h_core.sv -----
module r2h_core
    import r2h_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    output res_t       res
);

    logic [7:0] buf_reg  [BufDepth];
    logic [7:0] buf_next [BufDepth];
    logic [1:0] len_reg, len_next;
    logic [7:0] ovf_reg, ovf_next;

    logic [7:0] c, n0, n1, n2, a0, a1, a2, b0, b1, b2;
    logic [1:0] ln, la, lb, hlen, pre;
    logic [13:0] p0, p1, k0, k1;
    logic       del;
    logic       typing;
    entry_t     e3, e2, e1, hit_e;

    always_comb begin
        buf_next = buf_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        del      = 1'b0;
        typing   = 1'b0;
        c  = fold_case(char_code);
        n0 = buf_reg[0];
        n1 = buf_reg[1];
        n2 = buf_reg[2];
        unique case (len_reg)
            2'd0: n0 = c;
            2'd1: n1 = c;
            default: n2 = c;
        endcase
        ln  = len_reg + 2'd1;
        pre = 2'd0;
        p0  = '0;
        p1  = '0;
        a0 = n0; a1 = n1; a2 = n2; la = ln;
        if (ln >= 2'd2 && n0 == "n" && !is_vowel(n1) && n1 != "y" && n1 != "n") begin
            pre = 2'd1;
            p0  = KanaN;
            a0 = n1; a1 = n2; la = ln - 2'd1;
        end
        b0 = a0; b1 = a1; b2 = a2; lb = la;
        if (la >= 2'd2 && a0 == a1 && !is_vowel(a0) && a0 != "n") begin
            if (pre == 2'd0) begin
                p0 = KanaSmallTsu;
            end else begin
                p1 = KanaSmallTsu;
            end
            pre = pre + 2'd1;
            b0 = a1; b1 = a2; lb = la - 2'd1;
        end
        e3 = lookup3({b0, b1, b2});
        e2 = lookup2({b0, b1});
        e1 = lookup1(b0);
        priority if (lb == 2'd3 && e3.hit) begin
            hit_e = e3; hlen = 2'd3;
        end else if (lb >= 2'd2 && e2.hit) begin
            hit_e = e2; hlen = 2'd2;
        end else if (lb >= 2'd1 && e1.hit) begin
            hit_e = e1; hlen = 2'd1;
        end else begin
            hit_e = '0; hlen = 2'd0;
        end
        k0 = p0;
        k1 = p1;
        if (pre == 2'd0 && hit_e.hit) begin
            k0 = hit_e.k0;
            k1 = hit_e.k1;
        end else if (pre == 2'd1 && hit_e.hit) begin
            k1 = hit_e.k0;
        end

        unique case (func)
            FUNC_CHAR: begin
                if (len_reg == 2'd3) begin
                    if (ovf_reg != 8'hFF) begin
                        ovf_next = ovf_reg + 8'd1;
                    end
                end else begin
                    typing   = 1'b1;
                    len_next = lb - hlen;
                    unique case (hlen)
                        2'd1: begin
                            buf_next[0] = b1;
                            buf_next[1] = b2;
                            buf_next[2] = b2;
                        end
                        2'd2: begin
                            buf_next[0] = b2;
                            buf_next[1] = b1;
                            buf_next[2] = b2;
                        end
                        default: begin
                            buf_next[0] = b0;
                            buf_next[1] = b1;
                            buf_next[2] = b2;
                        end
                    endcase
                end
            end
            FUNC_BACKSPACE: begin
                if (ovf_reg != 8'd0) begin
                    ovf_next = ovf_reg - 8'd1;
                end else if (len_reg != 2'd0) begin
                    len_next = len_reg - 2'd1;
                end else begin
                    del = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                len_next = 2'd0;
                ovf_next = 8'd0;
            end
            default: begin
            end
        endcase

        res.kana_valid     = typing && (pre != 2'd0 || hit_e.hit);
        res.two            = typing && (pre == 2'd2 || (pre == 2'd1 && hit_e.hit)
                             || (pre == 2'd0 && hit_e.hit && hit_e.k1 != 14'd0));
        res.kana0          = res.kana_valid ? k0 : 14'd0;
        res.kana1          = res.two ? k1 : 14'd0;
        res.delete_request = del;
        res.pending_chars  = {7'd0, len_next} + {1'b0, ovf_next};
        res.stuck          = (len_next == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 2'd0;
            ovf_reg <= 8'd0;
        end else if (fire) begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            buf_reg <= buf_next;
        end
    end

endmodule

// ----- rtl/r2h_out.sv -----
module r2h_out
    import r2h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  res_t        res_in,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kana_valid,
    output logic [13:0] m_kana,
    output logic        m_delete_request,
    output logic [8:0]  m_pending_chars,
    output logic        m_stuck,
    output logic        m_last
);

    res_t res_reg;
    logic valid_reg;
    logic beat_reg;
    logic take_last;

    assign m_valid          = valid_reg;
    assign m_kana_valid     = res_reg.kana_valid;
    assign m_kana           = beat_reg ? res_reg.kana1 : res_reg.kana0;
    assign m_delete_request = res_reg.delete_request;
    assign m_pending_chars  = res_reg.pending_chars;
    assign m_stuck          = res_reg.stuck;
    assign m_last           = !res_reg.two || beat_reg;
    assign take_last        = valid_reg && m_ready && m_last;
    assign free             = !valid_reg || take_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            beat_reg  <= 1'b0;
        end else if (take_last) begin
            valid_reg <= 1'b0;
            beat_reg  <= 1'b0;
        end else if (valid_reg && m_ready) begin
            beat_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

// ----- rtl/romaji_to_hiragana_converter.sv -----
// Romaji to hiragana converter. Each input beat carries a function code (typed
// character, backspace, clear) and an ASCII byte; each item yields one or two
// result beats, the last one flagged by m_last. A new input beat is taken every
// cycle while m_ready is high, so the rate is one item per cycle; an item that
// emits two kana holds the result register, and the next item, until its second
// beat is taken. Results pass through one input register and one result
// register with the transliteration logic between them.
module romaji_to_hiragana_converter
    import r2h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kana_valid,
    output logic [13:0] m_kana,
    output logic        m_delete_request,
    output logic [8:0]  m_pending_chars,
    output logic        m_stuck,
    output logic        m_last
);

    logic       in_valid_reg;
    logic [1:0] func_reg;
    logic [7:0] char_reg;
    logic       out_free;
    logic       advance;
    res_t       res;

    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
        end
    end

    r2h_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .func      (func_reg),
        .char_code (char_reg),
        .res       (res)
    );

    r2h_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (advance),
        .res_in           (res),
        .free             (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kana_valid     (m_kana_valid),
        .m_kana           (m_kana),
        .m_delete_request (m_delete_request),
        .m_pending_chars  (m_pending_chars),
        .m_stuck          (m_stuck),
        .m_last           (m_last)
    );

endmodule

// ----- rtl/r2h_checker.sv -----
module r2h_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kana_valid,
    input logic [13:0] m_kana,
    input logic        m_delete_request,
    input logic [8:0]  m_pending_chars,
    input logic        m_stuck,
    input logic        m_last
);

    // no kana code without the valid flag, and no delete request with a kana
    a_kana_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kana_valid |-> m_kana == 14'd0 && m_last)
        else $error("kana nonzero on status beat");

    a_del_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_delete_request |-> !m_kana_valid)
        else $error("delete request with kana");

    a_stuck_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stuck |-> m_pending_chars >= 9'd3)
        else $error("stuck with fewer than three pending");

    // first of a kana pair is followed by its partner with the same status
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_kana_valid && m_last
            && $stable(m_pending_chars) && $stable(m_stuck))
        else $error("second kana beat missing or status changed");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kana) && $stable(m_last))
        else $error("result beat changed while stalled");

endmodule

bind romaji_to_hiragana_converter r2h_checker u_r2h_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kana_valid     (m_kana_valid),
    .m_kana           (m_kana),
    .m_delete_request (m_delete_request),
    .m_pending_chars  (m_pending_chars),
    .m_stuck          (m_stuck),
    .m_last           (m_last)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import r2h_pkg::*;
();

    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam logic [13:0] KANA_N       = 14'h3093;
    localparam logic [13:0] KANA_SOKUON  = 14'h3063;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic        kana_valid;
        logic [13:0] kana;
        logic        delete_request;
        logic [8:0]  pending_chars;
        logic        stuck;
        logic        last;
    } kana_beat_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func      = 2'd0;
    logic [7:0]  s_char_code = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_kana_valid;
    logic [13:0] m_kana;
    logic        m_delete_request;
    logic [8:0]  m_pending_chars;
    logic        m_stuck;
    logic        m_last;

    // romaji -> {k0, k1}; key is {length, up to three bytes}
    logic [27:0] kana_of [logic [25:0]];
    string       syllables [$];

    logic [7:0]  romaji_buf [0:2];
    int          romaji_len = 0;
    int          spill_cnt  = 0;
    kana_beat_t  kana_expect_q [$];

    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    int          stall_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned keys_sent    = 0;
    int unsigned beats_seen   = 0;
    int unsigned kana_seen    = 0;
    int unsigned dels_seen    = 0;
    int unsigned bad_beats    = 0;
    kana_beat_t  got_beat;
    kana_beat_t  want_beat;

    romaji_to_hiragana_converter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_char_code      (s_char_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kana_valid     (m_kana_valid),
        .m_kana           (m_kana),
        .m_delete_request (m_delete_request),
        .m_pending_chars  (m_pending_chars),
        .m_stuck          (m_stuck),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, kana_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // ---------------- kana table ----------------

    function automatic void put(input string r, input logic [13:0] k0, input logic [13:0] k1);
        logic [25:0] key;
        int          n;
        int          j;
        n = r.len();
        key = {n[1:0], 24'h0};
        for (j = 0; j < n; j++) key[23-8*j -: 8] = r[j];
        kana_of[key] = {k0, k1};
        syllables.push_back(r);
    endfunction

    function automatic void row5(input string c, input logic [13:0] ka, input logic [13:0] ki,
                                 input logic [13:0] ku, input logic [13:0] ke,
                                 input logic [13:0] ko);
        put({c, "a"}, ka, 14'h0);
        put({c, "i"}, ki, 14'h0);
        put({c, "u"}, ku, 14'h0);
        put({c, "e"}, ke, 14'h0);
        put({c, "o"}, ko, 14'h0);
    endfunction

    function automatic void yoon3(input string c, input logic [13:0] k0);
        put({c, "a"}, k0, 14'h3083);
        put({c, "u"}, k0, 14'h3085);
        put({c, "o"}, k0, 14'h3087);
    endfunction

    task automatic load_kana_table();
        put("shi", 14'h3057, 14'h0);
        put("chi", 14'h3061, 14'h0);
        put("tsu", 14'h3064, 14'h0);
        yoon3("sh", 14'h3057);
        yoon3("ch", 14'h3061);
        yoon3("ty", 14'h3061);
        yoon3("sy", 14'h3057);
        yoon3("ny", 14'h306B);
        yoon3("hy", 14'h3072);
        yoon3("my", 14'h307F);
        yoon3("ry", 14'h308A);
        yoon3("gy", 14'h304E);
        yoon3("by", 14'h3073);
        yoon3("py", 14'h3074);
        yoon3("ky", 14'h304D);
        yoon3("jy", 14'h3058);
        put("xtu", 14'h3063, 14'h0);
        put("xya", 14'h3083, 14'h0);
        put("xyu", 14'h3085, 14'h0);
        put("xyo", 14'h3087, 14'h0);
        put("xwa", 14'h308E, 14'h0);
        row5("k", 14'h304B, 14'h304D, 14'h304F, 14'h3051, 14'h3053);
        row5("s", 14'h3055, 14'h3057, 14'h3059, 14'h305B, 14'h305D);
        row5("t", 14'h305F, 14'h3061, 14'h3064, 14'h3066, 14'h3068);
        row5("n", 14'h306A, 14'h306B, 14'h306C, 14'h306D, 14'h306E);
        row5("h", 14'h306F, 14'h3072, 14'h3075, 14'h3078, 14'h307B);
        row5("m", 14'h307E, 14'h307F, 14'h3080, 14'h3081, 14'h3082);
        row5("r", 14'h3089, 14'h308A, 14'h308B, 14'h308C, 14'h308D);
        row5("w", 14'h308F, 14'h3090, 14'h3046, 14'h3091, 14'h3092);
        row5("g", 14'h304C, 14'h304E, 14'h3050, 14'h3052, 14'h3054);
        row5("z", 14'h3056, 14'h3058, 14'h305A, 14'h305C, 14'h305E);
        row5("d", 14'h3060, 14'h3062, 14'h3065, 14'h3067, 14'h3069);
        row5("b", 14'h3070, 14'h3073, 14'h3076, 14'h3079, 14'h307C);
        row5("p", 14'h3071, 14'h3074, 14'h3077, 14'h307A, 14'h307D);
        row5("x", 14'h3041, 14'h3043, 14'h3045, 14'h3047, 14'h3049);
        row5("",  14'h3042, 14'h3044, 14'h3046, 14'h3048, 14'h304A);
        put("ya", 14'h3084, 14'h0);
        put("yi", 14'h3044, 14'h0);
        put("yu", 14'h3086, 14'h0);
        put("ye", 14'h3044, 14'h3047);
        put("yo", 14'h3088, 14'h0);
        put("fa", 14'h3075, 14'h3041);
        put("fi", 14'h3075, 14'h3043);
        put("fu", 14'h3075, 14'h0);
        put("fe", 14'h3075, 14'h3047);
        put("fo", 14'h3075, 14'h3049);
        put("ja", 14'h3058, 14'h3083);
        put("ji", 14'h3058, 14'h0);
        put("ju", 14'h3058, 14'h3085);
        put("je", 14'h3058, 14'h3047);
        put("jo", 14'h3058, 14'h3087);
        put("nn", 14'h3093, 14'h0);
    endtask

    // ---------------- predictor ----------------

    function automatic bit plain_vowel(input logic [7:0] ch);
        return ch == "a" || ch == "i" || ch == "u" || ch == "e" || ch == "o";
    endfunction

    function automatic void shift_out(input int n);
        int i;
        if (n >= romaji_len) begin
            romaji_len = 0;
        end else begin
            for (i = 0; i + n < romaji_len; i++) romaji_buf[i] = romaji_buf[i+n];
            romaji_len -= n;
        end
    endfunction

    task automatic predict_kana(input logic [1:0] f, input logic [7:0] c);
        logic [13:0] out_kana [$];
        logic        del;
        logic [7:0]  ch;
        logic [25:0] key;
        logic [27:0] hit;
        kana_beat_t  beat;
        int          l;
        int          j;
        int          k;
        del = 1'b0;
        ch = c;
        case (f)
            FUNC_CHAR: begin
                if (romaji_len == 3) begin
                    if (spill_cnt < 255) spill_cnt++;
                end else begin
                    if (ch >= "A" && ch <= "Z") ch = ch + 8'h20;
                    romaji_buf[romaji_len] = ch;
                    romaji_len++;
                    if (romaji_len >= 2 && romaji_buf[0] == "n" && !plain_vowel(romaji_buf[1])
                        && romaji_buf[1] != "y" && romaji_buf[1] != "n") begin
                        out_kana.push_back(KANA_N);
                        shift_out(1);
                    end
                    if (out_kana.size() < 2 && romaji_len >= 2
                        && romaji_buf[0] == romaji_buf[1] && !plain_vowel(romaji_buf[0])
                        && romaji_buf[0] != "n") begin
                        out_kana.push_back(KANA_SOKUON);
                        shift_out(1);
                    end
                    for (l = 3; l >= 1; l--) begin
                        if (romaji_len >= l) begin
                            key = {l[1:0], 24'h0};
                            for (j = 0; j < l; j++) key[23-8*j -: 8] = romaji_buf[j];
                            if (kana_of.exists(key)) begin
                                hit = kana_of[key];
                                if (out_kana.size() < 2) out_kana.push_back(hit[27:14]);
                                if (hit[13:0] != 14'h0 && out_kana.size() < 2)
                                    out_kana.push_back(hit[13:0]);
                                shift_out(l);
                                break;
                            end
                        end
                    end
                end
            end
            FUNC_BACKSPACE: begin
                if (spill_cnt > 0) spill_cnt--;
                else if (romaji_len > 0) romaji_len--;
                else del = 1'b1;
            end
            FUNC_CLEAR: begin
                romaji_len = 0;
                spill_cnt  = 0;
            end
            default: ;
        endcase
        beat.pending_chars = 9'(romaji_len + spill_cnt);
        beat.stuck = (romaji_len == 3);
        if (out_kana.size() == 0) begin
            beat.kana_valid     = 1'b0;
            beat.kana           = 14'h0;
            beat.delete_request = del;
            beat.last           = 1'b1;
            kana_expect_q.push_back(beat);
        end else begin
            for (k = 0; k < out_kana.size(); k++) begin
                beat.kana_valid     = 1'b1;
                beat.kana           = out_kana[k];
                beat.delete_request = 1'b0;
                beat.last           = (k == out_kana.size() - 1);
                kana_expect_q.push_back(beat);
            end
        end
    endtask

    // ---------------- result checker ----------------

    function automatic void flag_beat(input string what, input kana_beat_t want,
                                      input kana_beat_t got);
        bad_beats++;
        if (bad_beats <= 10) begin
            $display("%s: exp kv=%0d kana=%h del=%0d pend=%0d stuck=%0d last=%0d",
                     what, want.kana_valid, want.kana, want.delete_request,
                     want.pending_chars, want.stuck, want.last);
            $display("    got kv=%0d kana=%h del=%0d pend=%0d stuck=%0d last=%0d",
                     got.kana_valid, got.kana, got.delete_request,
                     got.pending_chars, got.stuck, got.last);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_beat = {m_kana_valid, m_kana, m_delete_request, m_pending_chars,
                        m_stuck, m_last};
            beats_seen++;
            if (got_beat.kana_valid) kana_seen++;
            if (got_beat.delete_request) dels_seen++;
            if (kana_expect_q.size() == 0) begin
                flag_beat("unexpected beat", '0, got_beat);
            end else begin
                want_beat = kana_expect_q.pop_front();
                if (got_beat !== want_beat) flag_beat("mismatch", want_beat, got_beat);
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_key(input logic [1:0] f, input logic [7:0] c);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_kana(f, c);
        keys_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (kana_expect_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_case(input logic [7:0] ch);
        if (ch >= "a" && ch <= "z" && $urandom_range(3) == 0) return ch - 8'h20;
        return ch;
    endfunction

    task automatic type_syllable();
        string syl;
        int    i;
        syl = syllables[$urandom_range(syllables.size() - 1)];
        case ($urandom_range(9))
            0: if (!plain_vowel(syl[0])) send_key(FUNC_CHAR, random_case(syl[0]));
            1: send_key(FUNC_CHAR, random_case("n"));
            default: ;
        endcase
        for (i = 0; i < syl.len(); i++) send_key(FUNC_CHAR, random_case(syl[i]));
    endtask

    task automatic test_directed_keys();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        send_key(FUNC_BACKSPACE, 8'hFF);   // empty buffer: delete request
        send_key(FUNC_UNUSED, 8'hFF);
        send_key(FUNC_CHAR, "K");
        send_key(FUNC_CHAR, "A");
        send_key(FUNC_CHAR, "k");
        send_key(FUNC_CHAR, "y");
        send_key(FUNC_CHAR, "a");
        send_key(FUNC_CHAR, "k");
        send_key(FUNC_CHAR, "k");          // sokuon
        send_key(FUNC_CHAR, "a");
        send_key(FUNC_CHAR, "n");
        send_key(FUNC_CHAR, "t");          // syllabic n
        send_key(FUNC_CHAR, "a");
        send_key(FUNC_CHAR, "y");
        send_key(FUNC_CHAR, "E");
        send_key(FUNC_CHAR, 8'h00);
        send_key(FUNC_CHAR, 8'hFF);
        send_key(FUNC_CHAR, "Z");          // buffer full, no match
        send_key(FUNC_CHAR, "q");
        send_key(FUNC_BACKSPACE, 8'h00);
        send_key(FUNC_BACKSPACE, 8'h00);
        send_key(FUNC_CLEAR, 8'h55);
        send_key(FUNC_CHAR, "n");
        send_key(FUNC_CHAR, "n");
        wait_results_drained();
    endtask

    task automatic test_overflow_saturation();
        int i;
        src_idle_pct = 5;
        dst_idle_pct = 5;
        send_key(FUNC_CHAR, "#");
        send_key(FUNC_CHAR, "7");
        send_key(FUNC_CHAR, "~");
        for (i = 0; i < 260; i++) send_key(FUNC_CHAR, 8'($urandom_range(255)));
        repeat (3) send_key(FUNC_BACKSPACE, 8'($urandom_range(255)));
        send_key(FUNC_CLEAR, 8'($urandom_range(255)));
        wait_results_drained();
    endtask

    task automatic test_random_typing(input int src_pct, input int dst_pct,
                                      input int unsigned count);
        int unsigned stop_at;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        stop_at = keys_sent + count;
        while (keys_sent < stop_at) begin
            if (romaji_len == 3 && $urandom_range(3) != 0) begin
                send_key(FUNC_CLEAR, 8'($urandom_range(255)));
            end else begin
                case ($urandom_range(19))
                    14:      send_key(FUNC_BACKSPACE, 8'($urandom_range(255)));
                    15:      send_key(FUNC_CLEAR, 8'($urandom_range(255)));
                    16:      send_key(FUNC_UNUSED, 8'($urandom_range(255)));
                    17, 18, 19: send_key(FUNC_CHAR, 8'($urandom_range(255)));
                    default: type_syllable();
                endcase
            end
        end
        wait_results_drained();
    endtask

    task automatic test_output_stall();
        int unsigned stop_at;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        stall_left = 300;
        stop_at = keys_sent + 40;
        while (keys_sent < stop_at) type_syllable();
        wait_results_drained();
    endtask

    initial begin
        load_kana_table();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_keys();
        test_overflow_saturation();
        test_random_typing(17, 86, 310);
        test_random_typing(86, 17, 310);
        test_output_stall();
        test_random_typing(0, 0, 310);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d keystroke beats sent, %0d result beats checked", keys_sent, beats_seen);
        $display("%0d kana emitted, %0d delete requests, %0d bad beats",
                 kana_seen, dels_seen, bad_beats);
        if (bad_beats == 0 && kana_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- romaji_to_hiragana_converter.f -----
rtl/r2h_pkg.sv
rtl/r2h_core.sv
rtl/r2h_out.sv
rtl/romaji_to_hiragana_converter.sv
rtl/r2h_checker.sv
verif/tb_top.sv
